// ----- hw/rtl/md5_hash_engine_macros.svh -----
// assertion macros shared by the md5 engine rtl
`ifndef MD5_HASH_ENGINE_MACROS_SVH
`define MD5_HASH_ENGINE_MACROS_SVH

`ifndef ASSERT_OFF
// property checked on every clock edge outside reset
`define MD5_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never hold outside reset
`define MD5_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MD5_ASSERT(lbl, clk, rst_n, prop, msg)
`define MD5_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ----- hw/rtl/md5_pkg.sv -----
package md5_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_ZERO,
    ST_LEN,
    ST_ROUND,
    ST_FOLD,
    ST_OUT0,
    ST_OUT1
  } state_e;

  // commands from the sequencer to the round unit
  typedef struct packed {
    logic load;
    logic step;
    logic fold;
    logic restart;
  } round_ctrl_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } chain_t;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  localparam logic [7:0] PadMarker    = 8'h80;
  localparam logic [5:0] FillLenStart = 6'd56;
  localparam logic [5:0] FillLast     = 6'd63;
  localparam logic [5:0] RoundLast    = 6'd63;
  localparam logic [1:0] LaneLast     = 2'd3;

  localparam int unsigned WordW      = 32;
  localparam int unsigned BlockWords = 16;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  // per-round left rotate amount
  function automatic logic [4:0] rot_amt(input logic [5:0] i);
    logic [4:0] s;
    unique case ({i[5:4], i[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
    endcase
    return s;
  endfunction

  // message word used by a round, arithmetic mod 16
  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] g;
    logic [3:0] lo;
    lo = i[3:0];
    unique case (i[5:4])
      2'd0: g = lo;
      2'd1: g = (lo << 2) + lo + 4'd1;
      2'd2: g = (lo << 1) + lo + 4'd5;
      2'd3: g = (lo << 3) - lo;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] byte_swap(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

// ----- hw/rtl/md5_ram.sv -----
module md5_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/md5_round.sv -----
module md5_round (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  md5_pkg::round_ctrl_t ctrl_i,
  input  logic [5:0]           rnd_i,
  input  logic [31:0]          word_i,
  output md5_pkg::chain_t      chain_o
);

  md5_pkg::chain_t chain_q, chain_d;
  md5_pkg::chain_t work_q, work_d;

  logic [31:0] f_val;
  logic [31:0] sum;
  logic [63:0] rot_dbl;
  logic [31:0] rot_val;

  // round function by group
  always_comb begin
    unique case (rnd_i[5:4])
      2'd0: f_val = (work_q.b & work_q.c) | (~work_q.b & work_q.d);
      2'd1: f_val = (work_q.d & work_q.b) | (~work_q.d & work_q.c);
      2'd2: f_val = work_q.b ^ work_q.c ^ work_q.d;
      2'd3: f_val = work_q.c ^ (work_q.b | ~work_q.d);
    endcase
  end

  assign sum     = work_q.a + f_val + md5_pkg::round_k(rnd_i) + word_i;
  assign rot_dbl = {sum, sum} << md5_pkg::rot_amt(rnd_i);
  assign rot_val = rot_dbl[63:32];

  always_comb begin
    work_d  = work_q;
    chain_d = chain_q;
    if (ctrl_i.load) begin
      work_d = chain_q;
    end
    if (ctrl_i.step) begin
      work_d.a = work_q.d;
      work_d.b = work_q.b + rot_val;
      work_d.c = work_q.b;
      work_d.d = work_q.c;
    end
    if (ctrl_i.fold) begin
      chain_d.a = chain_q.a + work_q.a;
      chain_d.b = chain_q.b + work_q.b;
      chain_d.c = chain_q.c + work_q.c;
      chain_d.d = chain_q.d + work_q.d;
    end
    if (ctrl_i.restart) begin
      chain_d = '{a: md5_pkg::InitA, b: md5_pkg::InitB,
                  c: md5_pkg::InitC, d: md5_pkg::InitD};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= '{a: md5_pkg::InitA, b: md5_pkg::InitB,
                   c: md5_pkg::InitC, d: md5_pkg::InitD};
    end else begin
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  assign chain_o = chain_q;

endmodule

// ----- hw/rtl/md5_hash_engine.sv -----
// compression: the byte that fills a 64-byte block starts 64 rounds of the shared round unit,
// one per cycle, followed by the chaining fold
// end of message: pad bytes (9..72) enter the block, each padded block is compressed, then 2 results
// throughput: 1 byte per cycle inside a block; requests stall while a full block is compressed
// reset: asynchronous active low; chaining words return to the md5 initial values,
// fill count and byte count clear; block memory contents stay undefined
`include "md5_hash_engine_macros.svh"

module md5_hash_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  // message byte requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic        s_axis_tuser,   // [0] no_byte
  input  logic        s_axis_tlast,   // end_of_message
  // digest halves
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] digest_half
  output logic        m_axis_tuser,   // [0] half_index
  output logic        m_axis_tlast    // last_half
);

  md5_pkg::state_e      state_q, state_d;
  md5_pkg::state_e      ret_q, ret_d;     // where to resume after a block compression
  md5_pkg::round_ctrl_t ctrl;
  md5_pkg::chain_t      chain;

  logic [5:0]  fill_q, fill_d;            // bytes held in the current block
  logic [60:0] total_q, total_d;          // message bytes, wraps mod 2^61
  logic [5:0]  rnd_q, rnd_d;              // round counter
  logic [23:0] wbuf_q, wbuf_d;            // lower three bytes of the word being built

  logic        put_en;                    // a byte enters the block this cycle
  logic [7:0]  put_val;
  logic        total_inc;
  logic        total_clr;

  logic [63:0] len_bits;
  logic [63:0] len_shift;
  logic [7:0]  len_byte;

  logic        mem_we;
  logic [3:0]  mem_waddr;
  logic [31:0] mem_wdata;
  logic [5:0]  rnd_next;
  logic [3:0]  mem_raddr;
  logic [31:0] mem_rdata;

  md5_pkg::state_e after_idle;

  // conditions watched by the checks below
  logic        req_clash;                 // input open while a digest is shown
  logic        round_end;                 // last round of a block
  logic        fold_start;                // fold with the round counter back at zero
  logic        len_slot;                  // not writing the trailer, or fill inside its slot
  logic        block_idle;                // no partial block and no rounds running

  // length trailer byte, little endian, picked by the low bits of the fill
  assign len_bits  = {total_q, 3'b000};
  assign len_shift = len_bits >> {fill_q[2:0], 3'b000};
  assign len_byte  = len_shift[7:0];

  assign after_idle = s_axis_tlast ? md5_pkg::ST_MARK : md5_pkg::ST_IDLE;

  // sequencer: message bytes, padding, rounds and digest output
  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    put_en    = 1'b0;
    put_val   = '0;
    ctrl      = '0;
    total_inc = 1'b0;
    total_clr = 1'b0;
    unique case (state_q)
      md5_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (!s_axis_tuser) begin
            put_en    = 1'b1;
            put_val   = s_axis_tdata;
            total_inc = 1'b1;
          end
          state_d = after_idle;
        end
      end
      md5_pkg::ST_MARK: begin
        put_en  = 1'b1;
        put_val = md5_pkg::PadMarker;
        state_d = md5_pkg::ST_ZERO;
      end
      md5_pkg::ST_ZERO: begin
        // zero fill until the length trailer slot
        if (fill_q == md5_pkg::FillLenStart) begin
          state_d = md5_pkg::ST_LEN;
        end else begin
          put_en = 1'b1;
        end
      end
      md5_pkg::ST_LEN: begin
        put_en  = 1'b1;
        put_val = len_byte;
        if (fill_q == md5_pkg::FillLast) begin
          state_d = md5_pkg::ST_OUT0;
        end
      end
      md5_pkg::ST_ROUND: begin
        ctrl.step = 1'b1;
        if (rnd_q == md5_pkg::RoundLast) begin
          state_d = md5_pkg::ST_FOLD;
        end
      end
      md5_pkg::ST_FOLD: begin
        ctrl.fold = 1'b1;
        state_d   = ret_q;
      end
      md5_pkg::ST_OUT0: begin
        if (m_axis_tready) begin
          state_d = md5_pkg::ST_OUT1;
        end
      end
      md5_pkg::ST_OUT1: begin
        if (m_axis_tready) begin
          ctrl.restart = 1'b1;
          total_clr    = 1'b1;
          state_d      = md5_pkg::ST_IDLE;
        end
      end
    endcase
    // the byte that completes a block diverts into compression
    if (put_en && fill_q == md5_pkg::FillLast) begin
      ctrl.load = 1'b1;
      ret_d     = state_d;
      state_d   = md5_pkg::ST_ROUND;
    end
  end

  // word assembly: bytes land little endian, full word goes to memory
  always_comb begin
    wbuf_d = wbuf_q;
    mem_we = 1'b0;
    if (put_en) begin
      unique case (fill_q[1:0])
        2'd0:              wbuf_d[7:0]   = put_val;
        2'd1:              wbuf_d[15:8]  = put_val;
        2'd2:              wbuf_d[23:16] = put_val;
        md5_pkg::LaneLast: mem_we        = 1'b1;
      endcase
    end
  end

  assign mem_waddr = fill_q[5:2];
  assign mem_wdata = {put_val, wbuf_q};

  assign fill_d  = put_en ? fill_q + 6'd1 : fill_q;
  assign total_d = total_clr ? '0 : (total_inc ? total_q + 61'd1 : total_q);
  assign rnd_d   = (state_q == md5_pkg::ST_ROUND) ? rnd_q + 6'd1 : rnd_q;

  // read one round ahead to cover the registered memory read
  assign rnd_next  = (state_q == md5_pkg::ST_ROUND) ? rnd_q + 6'd1 : '0;
  assign mem_raddr = md5_pkg::msg_index(rnd_next);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= md5_pkg::ST_IDLE;
      ret_q   <= md5_pkg::ST_IDLE;
      fill_q  <= '0;
      total_q <= '0;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      fill_q  <= fill_d;
      total_q <= total_d;
      rnd_q   <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wbuf_q <= wbuf_d;
  end

  // block store, sixteen little-endian words
  md5_ram #(
    .WIDTH(md5_pkg::WordW),
    .DEPTH(md5_pkg::BlockWords)
  ) u_block_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // shared round unit with chaining words
  md5_round u_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .rnd_i  (rnd_q),
    .word_i (mem_rdata),
    .chain_o(chain)
  );

  assign s_axis_tready = (state_q == md5_pkg::ST_IDLE);

  // digest halves straight from the chaining registers, hex-string byte order
  assign m_axis_tvalid = (state_q == md5_pkg::ST_OUT0) || (state_q == md5_pkg::ST_OUT1);
  assign m_axis_tuser  = (state_q == md5_pkg::ST_OUT1);
  assign m_axis_tlast  = (state_q == md5_pkg::ST_OUT1);
  assign m_axis_tdata  = (state_q == md5_pkg::ST_OUT1) ?
                         {md5_pkg::byte_swap(chain.c), md5_pkg::byte_swap(chain.d)} :
                         {md5_pkg::byte_swap(chain.a), md5_pkg::byte_swap(chain.b)};

  assign req_clash  = s_axis_tready && m_axis_tvalid;
  assign round_end  = (state_q == md5_pkg::ST_ROUND) && (rnd_q == md5_pkg::RoundLast);
  assign fold_start = (state_q == md5_pkg::ST_FOLD) && (rnd_q == '0);
  assign len_slot   = (state_q != md5_pkg::ST_LEN) || (fill_q >= md5_pkg::FillLenStart);
  assign block_idle = (fill_q == '0) && (rnd_q == '0);

  `MD5_ASSERT_NEVER(a_no_req_during_digest, clk_i, rst_ni, req_clash, "request in digest")
  `MD5_ASSERT(a_fold_after_rounds, clk_i, rst_ni, round_end |=> fold_start, "fold missing")
  `MD5_ASSERT(a_trailer_at_56, clk_i, rst_ni, len_slot, "length trailer outside its slot")
  `MD5_ASSERT(a_digest_block_empty, clk_i, rst_ni, m_axis_tvalid |-> block_idle, "partial block")

endmodule

// ----- bench/tb_md5_hash_engine.sv -----
module tb_md5_hash_engine;

  // md5 initial chaining words a, b, c, d
  localparam logic [31:0] ChainInit [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  // additive round constants, one per round
  localparam logic [31:0] RoundAdd [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // left rotate amounts, four per group of sixteen rounds
  localparam int RoundShift [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  localparam logic [7:0] PadMarker = 8'h80;
  localparam logic [5:0] LengthSlot = 6'd56;

  // cycles with no handshake on either side before the run is declared hung;
  // covers the receiver hold-off plus a worst case two-block finish
  localparam int WatchdogLimit = 4000;
  localparam int HoldOffCycles = 400;
  localparam int DrainCycles   = 200;
  localparam int TargetRequests = 850;
  localparam int MinMessages    = 30;

  typedef struct packed {
    logic [63:0] half;
    logic        index;
    logic        last;
  } digest_half_t;

  // keeps its own md5 state and queues the digest halves each end request yields
  class md5_digest_board;
    logic [31:0]  chain [4];
    logic [7:0]   block_bytes [64];
    logic [5:0]   fill;
    logic [60:0]  total;
    digest_half_t pending_halves [$];
    int           failures;

    function new();
      failures = 0;
      restart();
    endfunction

    function void restart();
      for (int k = 0; k < 4; k++) chain[k] = ChainInit[k];
      fill  = '0;
      total = '0;
    endfunction

    function logic [31:0] hex_order(logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function void compress_block();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, f, t, sum;
      int g;
      int s;
      for (int k = 0; k < 16; k++)
        w[k] = {block_bytes[4*k+3], block_bytes[4*k+2], block_bytes[4*k+1], block_bytes[4*k]};
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int i = 0; i < 64; i++) begin
        case (i / 16)
          0: begin
            f = (b & c) | (~b & d);
            g = i;
          end
          1: begin
            f = (d & b) | (~d & c);
            g = (5 * i + 1) % 16;
          end
          2: begin
            f = b ^ c ^ d;
            g = (3 * i + 5) % 16;
          end
          default: begin
            f = c ^ (b | ~d);
            g = (7 * i) % 16;
          end
        endcase
        s   = RoundShift[(i / 16) * 4 + (i % 4)];
        sum = a + f + RoundAdd[i] + w[g];
        t = d;
        d = c;
        c = b;
        b = b + ((sum << s) | (sum >> (32 - s)));
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
    endfunction

    function void absorb_byte(logic [7:0] value);
      block_bytes[fill] = value;
      fill++;
      if (fill == 6'd0) compress_block();
    endfunction

    function void note_request(logic [7:0] value, logic no_byte, logic end_of_msg);
      logic [63:0]  bit_len;
      digest_half_t out;
      if (!no_byte) begin
        absorb_byte(value);
        total++;
      end
      if (!end_of_msg) return;
      // bit length wraps mod 2^64 along with the byte count
      bit_len = {total, 3'b000};
      absorb_byte(PadMarker);
      while (fill != LengthSlot) absorb_byte(8'h00);
      for (int k = 0; k < 8; k++) absorb_byte(bit_len[8*k +: 8]);
      out.half  = {hex_order(chain[0]), hex_order(chain[1])};
      out.index = 1'b0;
      out.last  = 1'b0;
      pending_halves.push_back(out);
      out.half  = {hex_order(chain[2]), hex_order(chain[3])};
      out.index = 1'b1;
      out.last  = 1'b1;
      pending_halves.push_back(out);
      restart();
    endfunction

    function void check_result(logic [63:0] half, logic index, logic last);
      digest_half_t want;
      if (pending_halves.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected digest half %h (index %0d, last %0d)", half, index, last);
        return;
      end
      want = pending_halves.pop_front();
      if (want.half !== half || want.index !== index || want.last !== last) begin
        failures++;
        if (failures <= 10)
          $display("digest half mismatch: expected %h index %0d last %0d, got %h index %0d last %0d",
                   want.half, want.index, want.last, half, index, last);
      end
    endfunction

    function int pending();
      return pending_halves.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] byte_value
  logic        s_axis_tuser = 1'b0;    // [0] no_byte
  logic        s_axis_tlast = 1'b0;    // end_of_message
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;           // [63:0] digest_half
  logic        m_axis_tuser;           // [0] half_index
  logic        m_axis_tlast;           // last_half

  md5_digest_board digests;
  int  requests_sent = 0;
  int  messages_sent = 0;
  int  halves_seen = 0;
  int  quiet_cycles = 0;
  bit  send_gaps = 1'b1;

  md5_hash_engine u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // both handshakes sampled at the rising edge, before any flop in the block updates
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        digests.note_request(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        digests.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        halves_seen++;
      end
    end
  end

  // watchdog: any request or digest half taken restarts the count
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("timeout: no handshake for %0d cycles", WatchdogLimit);
        $display("md5_hash_engine test failed");
        $finish;
      end
    end
  end

  // digest receiver: random stalls, one long hold-off once a few digests are out
  // so the engine backs up into its input, and a stretch with no stalls at all
  initial begin
    int  hold_left;
    bit  held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && halves_seen >= 8) begin
        held = 1'b1;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (halves_seen >= 20 && halves_seen < 40) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 9);
      end
    end
  end

  // one request; tvalid stays up into the next request unless a gap is drawn
  task automatic send_request(input logic [7:0] value, input logic no_byte,
                              input logic end_of_msg);
    while (send_gaps && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= no_byte;
    s_axis_tlast  <= end_of_msg;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (!no_byte || end_of_msg) requests_sent++;
    // no stall stretch in the middle of the random part
    send_gaps = !(requests_sent >= 350 && requests_sent < 500);
    @(negedge clk_i);
  endtask

  // message of len bytes with random content and the odd empty request mixed in;
  // the end rides on the last byte or on a separate request with no byte
  task automatic send_message(input int len, input bit end_on_byte);
    for (int n = 0; n < len; n++) begin
      if ($urandom_range(99) < 5)
        send_request(8'($urandom_range(255)), 1'b1, 1'b0);
      send_request(8'($urandom_range(255)), 1'b0, end_on_byte && (n == len - 1));
    end
    if (!end_on_byte || len == 0)
      send_request(8'($urandom_range(255)), 1'b1, 1'b1);
    messages_sent++;
  endtask

  // mostly short messages, many around the padding and block boundaries, a few long
  function automatic int pick_length();
    int lens [11] = '{55, 56, 57, 63, 64, 65, 119, 120, 121, 127, 128};
    int r;
    r = $urandom_range(99);
    if (r < 45) return $urandom_range(16);
    if (r < 75) return lens[$urandom_range(10)];
    if (r < 95) return $urandom_range(130, 17);
    return $urandom_range(260, 131);
  endfunction

  initial begin
    digests = new();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty message on a fresh engine; the byte lane is ignored
    send_request(8'hff, 1'b1, 1'b1);
    // empty request does nothing, then a one-byte message of zero
    send_request(8'ha5, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'hff, 1'b0, 1'b1);
    // "abc" closed by a request with no byte
    send_request(8'h61, 1'b0, 1'b0);
    send_request(8'h62, 1'b0, 1'b0);
    send_request(8'h63, 1'b0, 1'b0);
    send_request(8'h5a, 1'b1, 1'b1);
    // extreme byte values in one message
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'hff, 1'b0, 1'b0);
    send_request(8'h80, 1'b0, 1'b0);
    send_request(8'h7f, 1'b0, 1'b0);
    send_request(8'h01, 1'b0, 1'b0);
    send_request(8'hfe, 1'b0, 1'b1);
    // back to back empty messages
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'hff, 1'b1, 1'b1);

    while (requests_sent < TargetRequests || messages_sent < MinMessages)
      send_message(pick_length(), bit'($urandom_range(1)));
    s_axis_tvalid <= 1'b0;

    while (digests.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (digests.failures == 0) begin
      $display("md5_hash_engine test passed");
    end else begin
      $display("md5_hash_engine test failed");
    end
    $finish;
  end

endmodule
